/* rtl/core/ptts_pkg.sv */
// Shared types, codes and default sizes for the periodic task tick scheduler.
`default_nettype none

package ptts_pkg;

  // Default sizes for the top-level parameters.
  localparam int DefMaxTasks = 8;
  localparam int DefTimeBits = 16;

  // Fixed port widths.
  localparam int SlotW     = 3;
  localparam int OutcomeW  = 3;
  localparam int IndexW    = 3;
  localparam int PolicyW   = 2;
  localparam int CountW    = 4;
  localparam int CfgDataW  = 4;
  localparam int CfgIndexW = 1;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Outcome codes.
  localparam logic [OutcomeW-1:0] OUT_LOADED = 3'd0;
  localparam logic [OutcomeW-1:0] OUT_RAN    = 3'd1;
  localparam logic [OutcomeW-1:0] OUT_IDLE   = 3'd2;
  localparam logic [OutcomeW-1:0] OUT_ERROR  = 3'd3;
  localparam logic [OutcomeW-1:0] OUT_REJECT = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_POLICY = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_COUNT  = 1'b1;

  // Scheduling policy codes; the unused code behaves as rate monotonic.
  localparam logic [PolicyW-1:0] POL_RM  = 2'd0;
  localparam logic [PolicyW-1:0] POL_EDF = 2'd1;
  localparam logic [PolicyW-1:0] POL_LLF = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } ptts_state_e;

  // Per-entry decisions from the shared unit.
  typedef struct packed {
    logic overrun;  // remaining compute exceeds remaining deadline
    logic take;     // entry becomes the new best candidate
  } ptts_flags_t;

endpackage

`default_nettype wire

/* rtl/core/periodic_task_tick_scheduler.sv */
// Top level of the periodic task tick scheduler: sequencer, task table and shared unit.
//
// Usage: a transaction is taken at a rising clock edge with start high and busy low.
// command_i selects a load (task_slot_i, compute_budget_i, period_length_i) or one tick.
// Every transaction gives exactly one result on outcome_o and task_index_o, shown for
// one cycle with result_valid_o high; the receiver cannot stall and must take it then.
// A load, a rejected load, and a tick after a latched schedule error answer in the
// cycle after acceptance, with busy staying low, so the next transaction may follow.
// A tick makes two passes over the active entries through the single read port of the
// task RAM, one entry per cycle: a check-and-select pass, then an update pass that
// writes each entry back. A tick that finds a deadline miss answers after the check pass,
// without an update pass, and a tick with no active entry answers with the idle outcome.
// Busy falls in the cycle that shows the result, so the next transaction can be taken
// at the edge that ends it.
// Configuration (policy, task count) is written through cfg_we_i / cfg_index_i /
// cfg_data_i while the block is idle. Reset clears the configuration, the error flag
// and one valid bit per table entry; an entry not yet written reads as all zero, so
// no clearing pass is needed and the block is ready right after reset.
`default_nettype none

module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int MaxTasks = DefMaxTasks,
  parameter int TimeBits = DefTimeBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 command_i,
  input  wire logic [SlotW-1:0]     task_slot_i,
  input  wire logic [15:0]          compute_budget_i,
  input  wire logic [15:0]          period_length_i,
  output logic                      result_valid_o,
  output logic      [OutcomeW-1:0]  outcome_o,
  output logic      [IndexW-1:0]    task_index_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int IdxW   = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW   = $clog2(MaxTasks + 1);
  localparam int EntryW = 4 * TimeBits;

  // Configuration registers.
  logic [PolicyW-1:0] policy_q;
  logic [CountW-1:0]  count_q;
  logic [CntW-1:0]    act_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_RM;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POLICY: policy_q <= cfg_data_i[PolicyW-1:0];
        REG_COUNT:  count_q  <= cfg_data_i[CountW-1:0];
        default:    policy_q <= policy_q;
      endcase
    end
  end

  // Number of entries that take part in a tick.
  always_comb begin
    if (int'(count_q) > MaxTasks) begin
      act_n = CntW'(MaxTasks);
    end else begin
      act_n = CntW'(count_q);
    end
  end

  // Sequencer and scan registers.
  ptts_state_e         state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic                errf_q, errf_d;
  logic [IdxW-1:0]     err_idx_q, err_idx_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     pick_q, pick_d;
  logic [TimeBits-1:0] best_q, best_d;
  logic                err_seen_q, err_seen_d;
  logic [IdxW-1:0]     err_task_q, err_task_d;
  logic                res_vld_q, res_vld_d;
  logic [OutcomeW-1:0] res_out_q, res_out_d;
  logic [IndexW-1:0]   res_idx_q, res_idx_d;

  // Task table: RAM plus one valid bit per entry.
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [EntryW-1:0]   ram_wdata;
  logic [IdxW-1:0]     ram_raddr;
  logic [EntryW-1:0]   ram_rdata;
  logic [MaxTasks-1:0] valid_q;
  logic                rd_valid_q;
  logic [EntryW-1:0]   entry;

  ptts_ram #(
    .Width (EntryW),
    .Depth (MaxTasks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // An entry never written reads as all zero.
  assign entry = rd_valid_q ? ram_rdata : '0;

  // Shared unit on the entry just read.
  ptts_flags_t         flags;
  logic [TimeBits-1:0] key;
  logic [TimeBits-1:0] new_compute;
  logic [TimeBits-1:0] new_deadline;
  logic                dec_compute;

  assign dec_compute = found_q && (pend_idx_q == pick_q);

  ptts_alu #(
    .TimeBits (TimeBits)
  ) u_alu (
    .policy_i         (policy_q),
    .static_compute_i (entry[4*TimeBits-1:3*TimeBits]),
    .static_period_i  (entry[3*TimeBits-1:2*TimeBits]),
    .rem_compute_i    (entry[2*TimeBits-1:TimeBits]),
    .rem_deadline_i   (entry[TimeBits-1:0]),
    .have_best_i      (found_q),
    .best_key_i       (best_q),
    .dec_compute_i    (dec_compute),
    .flags_o          (flags),
    .key_o            (key),
    .new_compute_o    (new_compute),
    .new_deadline_o   (new_deadline)
  );

  // Load operands cut to the time width.
  logic [TimeBits-1:0] ld_compute;
  logic [TimeBits-1:0] ld_period;
  logic                ld_reject;

  assign ld_compute = TimeBits'(compute_budget_i);
  assign ld_period  = TimeBits'(period_length_i);
  assign ld_reject  = (ld_period == '0) || (int'(task_slot_i) >= MaxTasks);

  assign busy = (state_q != ST_IDLE);

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      errf_q     <= 1'b0;
      found_q    <= 1'b0;
      err_seen_q <= 1'b0;
      err_task_q <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      errf_q     <= errf_d;
      found_q    <= found_d;
      err_seen_q <= err_seen_d;
      err_task_q <= err_task_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    err_idx_q  <= err_idx_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
    res_out_q  <= res_out_d;
    res_idx_q  <= res_idx_d;
  end

  // Next state, table access and result.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    errf_d     = errf_q;
    err_idx_d  = err_idx_q;
    found_d    = found_q;
    pick_d     = pick_q;
    best_d     = best_q;
    err_seen_d = err_seen_q;
    err_task_d = err_task_q;
    res_vld_d  = 1'b0;
    res_out_d  = res_out_q;
    res_idx_d  = res_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = pend_idx_q;
    ram_wdata  = {entry[4*TimeBits-1:2*TimeBits], new_compute, new_deadline};
    ram_raddr  = cnt_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (command_i == CMD_LOAD) begin
            res_vld_d = 1'b1;
            res_idx_d = task_slot_i;
            if (ld_reject) begin
              res_out_d = OUT_REJECT;
            end else begin
              res_out_d = OUT_LOADED;
              ram_we    = 1'b1;
              ram_waddr = IdxW'(task_slot_i);
              ram_wdata = {ld_compute, ld_period, ld_compute, ld_period};
            end
          end else if (err_seen_q) begin
            res_vld_d = 1'b1;
            res_out_d = OUT_ERROR;
            res_idx_d = IndexW'(err_task_q);
          end else begin
            cnt_d   = '0;
            errf_d  = 1'b0;
            found_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle.
        if (cnt_q < act_n) begin
          cnt_d      = cnt_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IdxW-1:0];
        end
        if (pend_q) begin
          // First overrun is latched; the best candidate is tracked alongside.
          if (!errf_q && flags.overrun) begin
            errf_d    = 1'b1;
            err_idx_d = pend_idx_q;
          end
          if (flags.take) begin
            found_d = 1'b1;
            pick_d  = pend_idx_q;
            best_d  = key;
          end
        end else if (cnt_q >= act_n) begin
          if (errf_q) begin
            err_seen_d = 1'b1;
            err_task_d = err_idx_q;
            res_vld_d  = 1'b1;
            res_out_d  = OUT_ERROR;
            res_idx_d  = IndexW'(err_idx_q);
            state_d    = ST_IDLE;
          end else begin
            cnt_d   = '0;
            state_d = ST_UPDATE;
          end
        end
      end

      ST_UPDATE: begin
        if (cnt_q < act_n) begin
          cnt_d      = cnt_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IdxW-1:0];
        end
        if (pend_q) begin
          // Write the updated entry back.
          ram_we = 1'b1;
        end else if (cnt_q >= act_n) begin
          res_vld_d = 1'b1;
          if (found_q) begin
            res_out_d = OUT_RAN;
            res_idx_d = IndexW'(pick_q);
          end else begin
            res_out_d = OUT_IDLE;
            res_idx_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_valid_o = res_vld_q;
  assign outcome_o      = res_out_q;
  assign task_index_o   = res_idx_q;

endmodule

`default_nettype wire

/* rtl/core/ptts_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ptts_ram #(
  parameter int Width = 64,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/ptts_alu.sv */
// Shared per-entry unit: deadline check, ordering key compare and tick update.
`default_nettype none

module ptts_alu
  import ptts_pkg::*;
#(
  parameter int TimeBits = DefTimeBits
) (
  input  wire logic [PolicyW-1:0]  policy_i,
  input  wire logic [TimeBits-1:0] static_compute_i,
  input  wire logic [TimeBits-1:0] static_period_i,
  input  wire logic [TimeBits-1:0] rem_compute_i,
  input  wire logic [TimeBits-1:0] rem_deadline_i,
  input  wire logic                have_best_i,
  input  wire logic [TimeBits-1:0] best_key_i,
  input  wire logic                dec_compute_i,
  output ptts_flags_t              flags_o,
  output logic      [TimeBits-1:0] key_o,
  output logic      [TimeBits-1:0] new_compute_o,
  output logic      [TimeBits-1:0] new_deadline_o
);

  logic [TimeBits-1:0] comp_dec;
  logic [TimeBits-1:0] dl_dec;

  // Ordering key for the selected policy.
  always_comb begin
    unique case (policy_i)
      POL_EDF: key_o = rem_deadline_i;
      POL_LLF: key_o = rem_deadline_i - rem_compute_i;
      default: key_o = static_period_i;
    endcase
  end

  // Deadline check and candidate choice; ties go to the later entry.
  always_comb begin
    flags_o.overrun = rem_compute_i > rem_deadline_i;
    flags_o.take    = (rem_compute_i != '0) && (!have_best_i || (key_o <= best_key_i));
  end

  // Tick update: run the picked task, count the deadline down, reload on expiry.
  always_comb begin
    comp_dec = rem_compute_i - TimeBits'(dec_compute_i);
    dl_dec   = (rem_deadline_i != '0) ? (rem_deadline_i - TimeBits'(1)) : '0;
    if ((dl_dec == '0) && (comp_dec == '0)) begin
      new_compute_o  = static_compute_i;
      new_deadline_o = static_period_i;
    end else begin
      new_compute_o  = comp_dec;
      new_deadline_o = dl_dec;
    end
  end

endmodule

`default_nettype wire
